// File: design/mpfb_pkg.sv
`default_nettype none

package mpfb_pkg;

    localparam int COLUMNS      = 128;
    localparam int PAGE_ROWS    = 8;
    localparam int PAGES        = 4;

    localparam int STORE_BYTES  = COLUMNS * PAGES;
    localparam int DISPLAY_ROWS = PAGES * PAGE_ROWS;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int PG_W         = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROW_W        = $clog2(PAGE_ROWS);
    localparam int XS_W         = $clog2(COLUMNS + 256);
    localparam int YS_W         = $clog2(DISPLAY_ROWS + 64);

    typedef enum logic [2:0] {
        CMD_FILL      = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_TEST      = 3'd2,
        CMD_CLEAR_ALL = 3'd3,
        CMD_READ      = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        MOP_SET  = 3'd0,
        MOP_CLR  = 3'd1,
        MOP_TEST = 3'd2,
        MOP_ZERO = 3'd3,
        MOP_READ = 3'd4
    } t_mem_op;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] x_left;
        logic [4:0] y_top;
        logic [7:0] rect_width;
        logic [5:0] rect_height;
        logic [8:0] byte_index;
    } t_in_beat;

    typedef struct packed {
        logic       hit;
        logic [7:0] read_data;
    } t_out_beat;

    typedef struct packed {
        logic              valid;
        t_mem_op           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } t_mem_req;

    typedef struct packed {
        logic       valid;
        t_mem_op    op;
        logic [7:0] mask;
        logic [7:0] data;
    } t_mem_rsp;

    function automatic logic [7:0] row_mask(input logic [ROW_W-1:0] lo,
                                            input logic [ROW_W-1:0] hi);
        logic [7:0] lo_part;
        logic [7:0] hi_part;
        lo_part = 8'hFF << lo;
        hi_part = 8'hFF >> (3'(PAGE_ROWS - 1) - hi);
        return lo_part & hi_part;
    endfunction

endpackage

`default_nettype wire

// File: design/mono_page_framebuffer_rect_engine_unit.sv
`default_nettype none

// Page-organized 1 bpp framebuffer (COLUMNS x PAGES*8) with rectangle fill, clear and test,
// clear-all and byte readback; one result beat per command, hit for test, byte for read.
// The store is a single-port-write RAM walked one byte per cycle: a rectangle command visits
// each column covered in every page touched, a byte read one byte, and an empty or unknown
// command no byte. Clear-all and the clear pass after reset sweep all COLUMNS*PAGES bytes
// (512 at the default size); no command is taken during the reset pass. A new command
// is accepted while the previous result still waits on the output.
module mono_page_framebuffer_rect_engine_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  mpfb_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output mpfb_pkg::t_out_beat o_out_beat
);
    import mpfb_pkg::*;

    t_mem_req  mem_req;
    t_mem_rsp  mem_rsp;
    logic      res_valid;
    t_out_beat res;
    logic      res_free;
    logic      r_out_valid;
    t_out_beat r_out;

    assign res_free = !r_out_valid || i_out_ready;

    mpfb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_free  (res_free),
        .o_req       (mem_req),
        .i_rsp       (mem_rsp)
    );

    mpfb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

// File: design/mpfb_store.sv
`default_nettype none

module mpfb_store (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mpfb_pkg::t_mem_req  i_req,
    output mpfb_pkg::t_mem_rsp  o_rsp
);
    import mpfb_pkg::*;

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        r_rd_data;
    logic              r_s1_valid;
    t_mem_op           r_s1_op;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [7:0]        r_s1_mask;
    logic [7:0]        n_wr_data;
    logic              s1_modify;

    assign s1_modify = r_s1_valid && (r_s1_op == MOP_SET || r_s1_op == MOP_CLR);

    always_comb begin
        case (r_s1_op)
            MOP_SET: n_wr_data = r_rd_data | r_s1_mask;
            default: n_wr_data = r_rd_data & ~r_s1_mask;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.op != MOP_ZERO) begin
            r_rd_data <= mem[i_req.addr];
        end
        if (s1_modify) begin
            mem[r_s1_addr] <= n_wr_data;
        end else if (i_req.valid && i_req.op == MOP_ZERO) begin
            mem[i_req.addr] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid && i_req.op != MOP_ZERO;
        end
        r_s1_op   <= i_req.op;
        r_s1_addr <= i_req.addr;
        r_s1_mask <= i_req.mask;
    end

    assign o_rsp.valid = r_s1_valid;
    assign o_rsp.op    = r_s1_op;
    assign o_rsp.mask  = r_s1_mask;
    assign o_rsp.data  = r_rd_data;

endmodule

`default_nettype wire

// File: design/mpfb_seq.sv
`default_nettype none

module mpfb_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  mpfb_pkg::t_in_beat  i_in_beat,
    output logic                o_res_valid,
    output mpfb_pkg::t_out_beat o_res,
    input  wire                 i_res_free,
    output mpfb_pkg::t_mem_req  o_req,
    input  mpfb_pkg::t_mem_rsp  i_rsp
);
    import mpfb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state            r_state;
    t_in_beat          r_in;
    logic              r_clr_reply;
    logic [ADDR_W-1:0] r_clr_addr;
    t_mem_op           r_op;
    logic [COL_W-1:0]  r_x;
    logic [COL_W-1:0]  r_x0;
    logic [COL_W-1:0]  r_xlast;
    logic [PG_W-1:0]   r_page;
    logic [PG_W-1:0]   r_p0;
    logic [PG_W-1:0]   r_plast;
    logic [ADDR_W-1:0] r_base;
    logic [ROW_W-1:0]  r_ylo;
    logic [ROW_W-1:0]  r_yhi;
    logic              r_hit;
    logic [7:0]        r_data;

    logic [XS_W-1:0]   x_end_full;
    logic [XS_W-1:0]   x_end;
    logic [YS_W-1:0]   y_end_full;
    logic [YS_W-1:0]   y_end;
    logic [YS_W-1:0]   y_last;
    logic              rect_empty;
    logic              idx_ok;
    logic [ROW_W-1:0]  lo;
    logic [ROW_W-1:0]  hi;

    always_comb begin
        x_end_full = XS_W'(r_in.x_left) + XS_W'(r_in.rect_width);
        x_end      = (x_end_full > XS_W'(COLUMNS)) ? XS_W'(COLUMNS) : x_end_full;
        y_end_full = YS_W'(r_in.y_top) + YS_W'(r_in.rect_height);
        y_end      = (y_end_full > YS_W'(DISPLAY_ROWS)) ? YS_W'(DISPLAY_ROWS) : y_end_full;
        y_last     = y_end - YS_W'(1);
        rect_empty = (XS_W'(r_in.x_left) >= x_end) || (YS_W'(r_in.y_top) >= y_end);
        idx_ok     = 32'(r_in.byte_index) < STORE_BYTES;
        lo         = (r_page == r_p0) ? r_ylo : '0;
        hi         = (r_page == r_plast) ? r_yhi : ROW_W'(PAGE_ROWS - 1);
    end

    always_comb begin
        o_req.valid = 1'b0;
        o_req.op    = r_op;
        o_req.addr  = r_base + ADDR_W'(r_x);
        o_req.mask  = row_mask(lo, hi);
        unique case (r_state)
            S_CLEAR: begin
                o_req.valid = 1'b1;
                o_req.op    = MOP_ZERO;
                o_req.addr  = r_clr_addr;
            end
            S_SETUP: begin
                o_req.valid = (r_in.cmd == CMD_READ) && idx_ok;
                o_req.op    = MOP_READ;
                o_req.addr  = ADDR_W'(r_in.byte_index);
            end
            S_WALK: begin
                o_req.valid = 1'b1;
            end
            default: begin
                o_req.valid = 1'b0;
            end
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_FINISH);
    assign o_res.hit       = r_hit;
    assign o_res.read_data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                        r_state <= r_clr_reply ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    case (r_in.cmd)
                        CMD_FILL, CMD_CLEAR, CMD_TEST: begin
                            r_state <= rect_empty ? S_FINISH : S_WALK;
                        end
                        CMD_CLEAR_ALL: begin
                            r_state     <= S_CLEAR;
                            r_clr_addr  <= '0;
                            r_clr_reply <= 1'b1;
                        end
                        CMD_READ: begin
                            r_state <= idx_ok ? S_DRAIN : S_FINISH;
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_WALK: begin
                    if (r_x == r_xlast && r_page == r_plast) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in   <= i_in_beat;
            r_hit  <= 1'b0;
            r_data <= '0;
        end else if (i_rsp.valid) begin
            if (i_rsp.op == MOP_TEST && (i_rsp.data & i_rsp.mask) != 8'h00) begin
                r_hit <= 1'b1;
            end
            if (i_rsp.op == MOP_READ) begin
                r_data <= i_rsp.data;
            end
        end

        if (r_state == S_SETUP) begin
            case (r_in.cmd)
                CMD_FILL:  r_op <= MOP_SET;
                CMD_CLEAR: r_op <= MOP_CLR;
                default:   r_op <= MOP_TEST;
            endcase
            r_x     <= COL_W'(r_in.x_left);
            r_x0    <= COL_W'(r_in.x_left);
            r_xlast <= COL_W'(x_end - XS_W'(1));
            r_page  <= PG_W'(r_in.y_top >> ROW_W);
            r_p0    <= PG_W'(r_in.y_top >> ROW_W);
            r_plast <= PG_W'(y_last >> ROW_W);
            r_base  <= ADDR_W'(ADDR_W'(r_in.y_top >> ROW_W) * ADDR_W'(COLUMNS));
            r_ylo   <= r_in.y_top[ROW_W-1:0];
            r_yhi   <= y_last[ROW_W-1:0];
        end else if (r_state == S_WALK) begin
            if (r_x == r_xlast) begin
                r_x    <= r_x0;
                r_page <= r_page + PG_W'(1);
                r_base <= r_base + ADDR_W'(COLUMNS);
            end else begin
                r_x <= r_x + COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mpfb_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         IDLE_LIMIT      = 5000;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         RANDOM_BEATS    = 1900;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    logic [7:0] pixel_bytes [STORE_BYTES];
    t_out_beat  pending_results [$];
    int         mismatches   = 0;
    int         hold_request = 0;
    logic       rx_holding   = 1'b0;

    mono_page_framebuffer_rect_engine_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_out_beat apply_command(input t_in_beat b);
        t_out_beat  res;
        int         x_stop;
        int         y_stop;
        int         addr;
        logic [7:0] bit_sel;
        res    = '0;
        x_stop = int'(b.x_left) + int'(b.rect_width);
        y_stop = int'(b.y_top) + int'(b.rect_height);
        if (x_stop > COLUMNS) x_stop = COLUMNS;
        if (y_stop > DISPLAY_ROWS) y_stop = DISPLAY_ROWS;
        case (b.cmd)
            CMD_FILL, CMD_CLEAR, CMD_TEST: begin
                for (int y = int'(b.y_top); y < y_stop; y++) begin
                    bit_sel = 8'(1 << (y % PAGE_ROWS));
                    for (int x = int'(b.x_left); x < x_stop; x++) begin
                        addr = (y / PAGE_ROWS) * COLUMNS + x;
                        if (addr >= STORE_BYTES) continue;
                        if (b.cmd == CMD_FILL) begin
                            pixel_bytes[addr] = pixel_bytes[addr] | bit_sel;
                        end else if (b.cmd == CMD_CLEAR) begin
                            pixel_bytes[addr] = pixel_bytes[addr] & ~bit_sel;
                        end else if ((pixel_bytes[addr] & bit_sel) != 8'h00) begin
                            res.hit = 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR_ALL: begin
                foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
            end
            CMD_READ: begin
                if (int'(b.byte_index) < STORE_BYTES) res.read_data = pixel_bytes[b.byte_index];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_beat mk_beat(input logic [2:0] cmd, input int x, input int y,
                                         input int w, input int h, input int idx);
        t_in_beat b;
        b.cmd         = cmd;
        b.x_left      = 7'(x);
        b.y_top       = 5'(y);
        b.rect_width  = 8'(w);
        b.rect_height = 6'(h);
        b.byte_index  = 9'(idx);
        return b;
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        int       pick;
        int       shape;
        b.x_left     = 7'($urandom);
        b.y_top      = 5'($urandom);
        b.byte_index = 9'($urandom);
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        if (pick < 25)      b.cmd = CMD_FILL;
        else if (pick < 40) b.cmd = CMD_CLEAR;
        else if (pick < 65) b.cmd = CMD_TEST;
        else if (pick < 93) b.cmd = CMD_READ;
        else if (pick < 95) b.cmd = CMD_CLEAR_ALL;
        else                b.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        if (shape < 85) begin
            b.rect_width  = 8'($urandom_range(0, 12));
            b.rect_height = 6'($urandom_range(0, 10));
        end else if (shape < 97) begin
            b.rect_width  = 8'($urandom_range(0, 64));
            b.rect_height = 6'($urandom_range(0, 32));
        end else begin
            b.rect_width  = 8'($urandom);
            b.rect_height = 6'($urandom);
        end
        return b;
    endfunction

    // holds valid across back-to-back beats; gaps lower it explicitly
    task automatic send_beat(input t_in_beat b);
        in_beat  <= b;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_results.push_back(apply_command(b));
    endtask

    task automatic test_after_reset();
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 511));
    endtask

    task automatic test_display_corners();
        send_beat(mk_beat(CMD_FILL, 0, 0, 1, 1, 0));
        send_beat(mk_beat(CMD_FILL, 127, 31, 1, 1, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 511));
        send_beat(mk_beat(CMD_TEST, 127, 31, 1, 1, 0));
    endtask

    task automatic test_off_display();
        send_beat(mk_beat(CMD_FILL, 120, 28, 255, 63, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 504));
        send_beat(mk_beat(CMD_TEST, 1, 1, 119, 27, 0));
        send_beat(mk_beat(CMD_CLEAR, 124, 30, 255, 63, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 511));
    endtask

    task automatic test_empty_rects();
        send_beat(mk_beat(CMD_FILL, 0, 0, 0, 32, 0));
        send_beat(mk_beat(CMD_FILL, 0, 0, 128, 0, 0));
        send_beat(mk_beat(CMD_TEST, 0, 0, 0, 32, 0));
        send_beat(mk_beat(CMD_TEST, 0, 0, 128, 0, 0));
    endtask

    task automatic test_page_span();
        send_beat(mk_beat(CMD_FILL, 10, 5, 3, 6, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 138));
        send_beat(mk_beat(CMD_TEST, 12, 10, 1, 1, 0));
    endtask

    task automatic test_spare_codes();
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            send_beat(mk_beat(3'(c), 127, 31, 255, 63, 511));
        end
    endtask

    task automatic test_clear_all();
        send_beat(mk_beat(CMD_CLEAR_ALL, 0, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_READ, 0, 0, 0, 0, 504));
        send_beat(mk_beat(CMD_TEST, 0, 0, 128, 32, 0));
    endtask

    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        wait (rx_holding);
        for (int i = 0; i < 24; i++) begin
            send_beat(mk_beat(CMD_TEST, i * 5, i, 4, 3, 0));
        end
    endtask

    task automatic test_random_traffic(input int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            burst--;
            send_beat(random_beat());
        end
    endtask

    initial begin : receiver
        int stretch;
        int mode;
        stretch = 0;
        mode    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                rx_holding = 1'b1;
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                rx_holding   = 1'b0;
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(10, 150);
            end
            stretch--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 7);
                default: out_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual hit=%0b data=%02h",
                         $time, out_beat.hit, out_beat.read_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (out_beat.hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, want.hit, out_beat.hit);
                    mismatches++;
                end
                if (out_beat.read_data !== want.read_data) begin
                    $display("%0t: read_data mismatch, expected %02h, actual %02h",
                             $time, want.read_data, out_beat.read_data);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_display_corners();
        test_off_display();
        test_empty_rects();
        test_page_span();
        test_spare_codes();
        test_clear_all();
        test_output_backpressure();
        test_random_traffic(RANDOM_BEATS);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
design/mpfb_pkg.sv
design/mpfb_store.sv
design/mpfb_seq.sv
design/mono_page_framebuffer_rect_engine_unit.sv
bench/testbench.sv
